[rtl/ncell_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncell_pkg
// Shared constants and register codes for the neighbor cell enumerator.
// ----------------------------------------------------------------------------
package ncell_pkg;

  // Field widths
  localparam int CENTER_W   = 8;
  localparam int INDEX_W    = 24;
  localparam int SIZE_REG_W = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;

  // Defaults and sizing
  localparam int DEF_MAX_GRID_SIZE = 256;
  localparam int QUEUE_DEPTH       = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE_X = 3'd0,
    REG_GRID_SIZE_Y = 3'd1,
    REG_GRID_SIZE_Z = 3'd2,
    REG_REACH_X     = 3'd3,
    REG_REACH_Y     = 3'd4,
    REG_REACH_Z     = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

[rtl/ncell_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncell_cfg
// Configuration registers, grid sizes limited to the supported maximum and
// the registered xy-plane stride (size_x * size_y).
// ----------------------------------------------------------------------------
module ncell_cfg #(
  parameter int MAX_GRID_SIZE = ncell_pkg::DEF_MAX_GRID_SIZE,
  parameter int SW            = $clog2(MAX_GRID_SIZE + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ncell_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ncell_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic      [SW-1:0]                    size_x,
  output logic      [SW-1:0]                    size_y,
  output logic      [SW-1:0]                    size_z,
  output logic                                  reach_x,
  output logic                                  reach_y,
  output logic                                  reach_z,
  output logic      [ncell_pkg::INDEX_W-1:0]    stride_xy
);

  localparam int CMP_W = (SW > ncell_pkg::SIZE_REG_W + 1) ? SW : ncell_pkg::SIZE_REG_W + 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_GRID_SIZE);
  localparam logic [SW-1:0]    MAX_S = SW'(MAX_GRID_SIZE);

  logic [ncell_pkg::SIZE_REG_W-1:0] grid_size_x;
  logic [ncell_pkg::SIZE_REG_W-1:0] grid_size_y;
  logic [ncell_pkg::SIZE_REG_W-1:0] grid_size_z;
  logic [2*SW-1:0]                  prod_xy;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size_x <= ncell_pkg::SIZE_REG_W'(1);
      grid_size_y <= ncell_pkg::SIZE_REG_W'(1);
      grid_size_z <= ncell_pkg::SIZE_REG_W'(1);
      reach_x     <= 1'b1;
      reach_y     <= 1'b1;
      reach_z     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ncell_pkg::REG_GRID_SIZE_X: grid_size_x <= cfg_data[ncell_pkg::SIZE_REG_W-1:0];
        ncell_pkg::REG_GRID_SIZE_Y: grid_size_y <= cfg_data[ncell_pkg::SIZE_REG_W-1:0];
        ncell_pkg::REG_GRID_SIZE_Z: grid_size_z <= cfg_data[ncell_pkg::SIZE_REG_W-1:0];
        ncell_pkg::REG_REACH_X:     reach_x     <= cfg_data[0];
        ncell_pkg::REG_REACH_Y:     reach_y     <= cfg_data[0];
        ncell_pkg::REG_REACH_Z:     reach_z     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Limit sizes to the supported maximum
  assign size_x = (CMP_W'(grid_size_x) > MAX_C) ? MAX_S : SW'(grid_size_x);
  assign size_y = (CMP_W'(grid_size_y) > MAX_C) ? MAX_S : SW'(grid_size_y);
  assign size_z = (CMP_W'(grid_size_z) > MAX_C) ? MAX_S : SW'(grid_size_z);

  // Track the plane stride in a register behind the size registers
  assign prod_xy = size_x * size_y;

  always_ff @(posedge clk) begin
    stride_xy <= ncell_pkg::INDEX_W'(prod_xy);
  end

endmodule
`default_nettype wire

[rtl/ncell_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncell_front
// Accepts center requests, clamps the box on each axis, drops empty boxes
// and forms the base index of the first cell. Two registered stages.
// ----------------------------------------------------------------------------
module ncell_front #(
  parameter int MAX_GRID_SIZE = ncell_pkg::DEF_MAX_GRID_SIZE,
  parameter int SW            = $clog2(MAX_GRID_SIZE + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ncell_pkg::CENTER_W-1:0] center_x,
  input  wire logic [ncell_pkg::CENTER_W-1:0] center_y,
  input  wire logic [ncell_pkg::CENTER_W-1:0] center_z,
  input  wire logic [SW-1:0]                  size_x,
  input  wire logic [SW-1:0]                  size_y,
  input  wire logic [SW-1:0]                  size_z,
  input  wire logic                           reach_x,
  input  wire logic                           reach_y,
  input  wire logic                           reach_z,
  input  wire logic [ncell_pkg::INDEX_W-1:0]  stride_xy,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output logic      [SW-1:0]                  x_lo,
  output logic      [SW-1:0]                  x_hi,
  output logic      [SW-1:0]                  y_lo,
  output logic      [SW-1:0]                  y_hi,
  output logic      [SW-1:0]                  z_lo,
  output logic      [SW-1:0]                  z_hi,
  output logic      [ncell_pkg::INDEX_W-1:0]  base
);

  localparam int CMP_W = (SW > ncell_pkg::CENTER_W + 2) ? SW : ncell_pkg::CENTER_W + 2;

  function automatic logic [CMP_W-1:0] range_lo(input logic [ncell_pkg::CENTER_W-1:0] c,
                                                input logic r);
    logic [CMP_W-1:0] cw;
    cw = CMP_W'(c);
    return (cw >= CMP_W'(r)) ? cw - CMP_W'(r) : '0;
  endfunction

  function automatic logic [CMP_W-1:0] range_hi(input logic [ncell_pkg::CENTER_W-1:0] c,
                                                input logic r, input logic [SW-1:0] s);
    logic [CMP_W-1:0] top_c;
    logic [CMP_W-1:0] sw;
    top_c = CMP_W'(c) + CMP_W'(r) + CMP_W'(1'b1);
    sw    = CMP_W'(s);
    return (top_c > sw) ? sw : top_c;
  endfunction

  // Stage 1 registers
  logic                          s1_valid;
  logic [ncell_pkg::CENTER_W-1:0] cx;
  logic [ncell_pkg::CENTER_W-1:0] cy;
  logic [ncell_pkg::CENTER_W-1:0] cz;

  // Stage 1 logic
  logic [CMP_W-1:0] xl_w, xh_w, yl_w, yh_w, zl_w, zh_w;
  logic             s1_empty;
  logic [2*SW-1:0]  y_off;

  // Stage 2 registers
  logic            s2_valid;
  logic [SW-1:0]   s2_xl, s2_xh, s2_yl, s2_yh, s2_zl, s2_zh;
  logic [2*SW-1:0] s2_yoff;
  logic [SW+ncell_pkg::INDEX_W-1:0] z_off;

  logic s1_free;
  logic s2_free;

  assign s2_free  = !s2_valid || push_ready;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  // Capture center
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx <= center_x;
      cy <= center_y;
      cz <= center_z;
    end
  end

  // Clamp each axis and classify the box
  always_comb begin
    xl_w     = range_lo(cx, reach_x);
    xh_w     = range_hi(cx, reach_x, size_x);
    yl_w     = range_lo(cy, reach_y);
    yh_w     = range_hi(cy, reach_y, size_y);
    zl_w     = range_lo(cz, reach_z);
    zh_w     = range_hi(cz, reach_z, size_z);
    s1_empty = (xl_w >= xh_w) || (yl_w >= yh_w) || (zl_w >= zh_w);
  end

  assign y_off = SW'(yl_w) * size_x;

  // Advance to stage 2, dropping empty boxes
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && !s1_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_xl   <= SW'(xl_w);
      s2_xh   <= SW'(xh_w);
      s2_yl   <= SW'(yl_w);
      s2_yh   <= SW'(yh_w);
      s2_zl   <= SW'(zl_w);
      s2_zh   <= SW'(zh_w);
      s2_yoff <= y_off;
    end
  end

  // Form the base index of the first cell
  assign z_off = s2_zl * stride_xy;
  assign base  = ncell_pkg::INDEX_W'(s2_xl) + ncell_pkg::INDEX_W'(s2_yoff)
               + ncell_pkg::INDEX_W'(z_off);

  assign push_valid = s2_valid;
  assign x_lo       = s2_xl;
  assign x_hi       = s2_xh;
  assign y_lo       = s2_yl;
  assign y_hi       = s2_yh;
  assign z_lo       = s2_zl;
  assign z_hi       = s2_zh;

endmodule
`default_nettype wire

[rtl/ncell_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncell_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module ncell_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ncell_pkg::QUEUE_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data,
  output logic      [LW-1:0]    level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (level != LW'(DEPTH));
  assign pop_valid  = (level != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LW'(1);
      end
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/ncell_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncell_back
// Walks the clamped box (x outer, z inner) one cell per cycle while out_ready
// allows, stepping the linear index by additions; drives the result register.
// ----------------------------------------------------------------------------
module ncell_back #(
  parameter int MAX_GRID_SIZE = ncell_pkg::DEF_MAX_GRID_SIZE,
  parameter int SW            = $clog2(MAX_GRID_SIZE + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire logic [SW-1:0]                 x_lo,
  input  wire logic [SW-1:0]                 x_hi,
  input  wire logic [SW-1:0]                 y_lo,
  input  wire logic [SW-1:0]                 y_hi,
  input  wire logic [SW-1:0]                 z_lo,
  input  wire logic [SW-1:0]                 z_hi,
  input  wire logic [ncell_pkg::INDEX_W-1:0] base,
  input  wire logic [SW-1:0]                 size_x,
  input  wire logic [ncell_pkg::INDEX_W-1:0] stride_xy,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ncell_pkg::INDEX_W-1:0] cell_index,
  output logic                               last
);

  logic [SW-1:0] x, y, z;
  logic [SW-1:0] xh, yh, zh, yl, zl;
  logic [ncell_pkg::INDEX_W-1:0] idx;
  logic [ncell_pkg::INDEX_W-1:0] y_start;
  logic [ncell_pkg::INDEX_W-1:0] x_start;

  logic [SW-1:0] x_inc, y_inc, z_inc;
  logic          x_wrap, y_wrap, z_wrap;
  logic          is_last;
  logic          emit;
  logic          load;
  logic [ncell_pkg::INDEX_W-1:0] dx;
  logic [ncell_pkg::INDEX_W-1:0] row_next;
  logic [ncell_pkg::INDEX_W-1:0] col_next;

  assign x_inc    = x + SW'(1);
  assign y_inc    = y + SW'(1);
  assign z_inc    = z + SW'(1);
  assign x_wrap   = (x_inc == xh);
  assign y_wrap   = (y_inc == yh);
  assign z_wrap   = (z_inc == zh);
  assign is_last  = x_wrap && y_wrap && z_wrap;
  assign dx       = ncell_pkg::INDEX_W'(size_x);
  assign row_next = y_start + dx;
  assign col_next = x_start + ncell_pkg::INDEX_W'(1);

  assign emit      = busy && (!out_valid || out_ready);
  assign pop_ready = !busy || (emit && is_last);
  assign load      = pop_valid && pop_ready;

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (emit && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x       <= x_lo;
      y       <= y_lo;
      z       <= z_lo;
      xh      <= x_hi;
      yh      <= y_hi;
      zh      <= z_hi;
      yl      <= y_lo;
      zl      <= z_lo;
      idx     <= base;
      y_start <= base;
      x_start <= base;
    end else if (emit) begin
      if (!z_wrap) begin
        z   <= z_inc;
        idx <= idx + stride_xy;
      end else if (!y_wrap) begin
        z       <= zl;
        y       <= y_inc;
        idx     <= row_next;
        y_start <= row_next;
      end else if (!x_wrap) begin
        z       <= zl;
        y       <= yl;
        x       <= x_inc;
        idx     <= col_next;
        y_start <= col_next;
        x_start <= col_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_index <= idx;
      last       <= is_last;
    end
  end

endmodule
`default_nettype wire

[rtl/neighbor_cell_enumerator.sv]
`default_nettype none
// The first result of a request passes the front part's stage registers, the
// queue and the back part's walk registers into the result register. One
// result per cycle while out_ready holds; the back part's walk gives one
// result per cell of the clamped box (1 to 27); the front drops empty boxes.
// Reset clears the pipeline, queue and result valid, and returns grid sizes
// to 1 and reaches to 1; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// neighbor_cell_enumerator
// Enumerates linear indexes of grid cells around a center cell: front part
// clamps and classifies, queue decouples, back part walks the box.
// ----------------------------------------------------------------------------
module neighbor_cell_enumerator #(
  parameter int MAX_GRID_SIZE = ncell_pkg::DEF_MAX_GRID_SIZE
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ncell_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ncell_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ncell_pkg::CENTER_W-1:0]   center_x,
  input  wire logic [ncell_pkg::CENTER_W-1:0]   center_y,
  input  wire logic [ncell_pkg::CENTER_W-1:0]   center_z,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [ncell_pkg::INDEX_W-1:0]    cell_index,
  output logic                                  last
);

  localparam int SW    = $clog2(MAX_GRID_SIZE + 1);
  localparam int ENT_W = 6 * SW + ncell_pkg::INDEX_W;
  localparam int QLW   = $clog2(ncell_pkg::QUEUE_DEPTH + 1);

  logic [SW-1:0] size_x, size_y, size_z;
  logic          reach_x, reach_y, reach_z;
  logic [ncell_pkg::INDEX_W-1:0] stride_xy;

  logic                          push_valid, push_ready;
  logic [SW-1:0]                 f_xl, f_xh, f_yl, f_yh, f_zl, f_zh;
  logic [ncell_pkg::INDEX_W-1:0] f_base;
  logic [ENT_W-1:0]              push_data;

  logic                          pop_valid, pop_ready;
  logic [ENT_W-1:0]              pop_data;
  logic [SW-1:0]                 b_xl, b_xh, b_yl, b_yh, b_zl, b_zh;
  logic [ncell_pkg::INDEX_W-1:0] b_base;
  logic [QLW-1:0]                q_level;
  logic                          back_busy;

  ncell_cfg #(
    .MAX_GRID_SIZE (MAX_GRID_SIZE),
    .SW            (SW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .reach_x   (reach_x),
    .reach_y   (reach_y),
    .reach_z   (reach_z),
    .stride_xy (stride_xy)
  );

  ncell_front #(
    .MAX_GRID_SIZE (MAX_GRID_SIZE),
    .SW            (SW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .size_x     (size_x),
    .size_y     (size_y),
    .size_z     (size_z),
    .reach_x    (reach_x),
    .reach_y    (reach_y),
    .reach_z    (reach_z),
    .stride_xy  (stride_xy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .x_lo       (f_xl),
    .x_hi       (f_xh),
    .y_lo       (f_yl),
    .y_hi       (f_yh),
    .z_lo       (f_zl),
    .z_hi       (f_zh),
    .base       (f_base)
  );

  // Pack and unpack queue entries
  assign push_data = {f_xl, f_xh, f_yl, f_yh, f_zl, f_zh, f_base};
  assign {b_xl, b_xh, b_yl, b_yh, b_zl, b_zh, b_base} = pop_data;

  ncell_queue #(
    .WIDTH (ENT_W),
    .DEPTH (ncell_pkg::QUEUE_DEPTH),
    .LW    (QLW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .level      (q_level)
  );

  ncell_back #(
    .MAX_GRID_SIZE (MAX_GRID_SIZE),
    .SW            (SW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .x_lo       (b_xl),
    .x_hi       (b_xh),
    .y_lo       (b_yl),
    .y_hi       (b_yh),
    .z_lo       (b_zl),
    .z_hi       (b_zh),
    .base       (b_base),
    .size_x     (size_x),
    .stride_xy  (stride_xy),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_index (cell_index),
    .last       (last)
  );

  // Queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    q_level <= QLW'(ncell_pkg::QUEUE_DEPTH))
    else $error("queue level above depth");

  // Idle back part picks up a waiting request at once
  assert property (@(posedge clk) disable iff (rst)
    (!back_busy && q_level != '0) |=> back_busy)
    else $error("back part idle with queued request");

  // No result is shown right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

[test/neighbor_cell_enumerator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_cell_enumerator_tb
// Drives center cell requests through the enumerator under several grid and
// reach settings. A scoreboard rebuilds the clamped neighbor box of every
// accepted request and compares each emitted cell index and last flag, in
// order. The run uses random idling on both sides, a long output stall and a
// pause of the sender until the block drains.
// ----------------------------------------------------------------------------

class neighbor_box_scoreboard;

  typedef struct packed {
    logic [ncell_pkg::INDEX_W-1:0] index;
    logic                          last;
  } cell_t;

  localparam int unsigned GRID_LIMIT = ncell_pkg::DEF_MAX_GRID_SIZE;

  // Register mirror: grid sizes and reaches per axis (x, y, z)
  logic [ncell_pkg::SIZE_REG_W-1:0] grid_dim [3];
  logic                             reach_dim [3];

  cell_t       pending_cells [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned requests;
  int unsigned empty_boxes;

  function new();
    for (int a = 0; a < 3; a++) begin
      grid_dim[a]  = ncell_pkg::SIZE_REG_W'(1);
      reach_dim[a] = 1'b1;
    end
    errors      = 0;
    checked     = 0;
    requests    = 0;
    empty_boxes = 0;
  endfunction

  function void write_reg(input logic [ncell_pkg::CFG_IDX_W-1:0]  idx,
                          input logic [ncell_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ncell_pkg::REG_GRID_SIZE_X: grid_dim[0]  = data;
      ncell_pkg::REG_GRID_SIZE_Y: grid_dim[1]  = data;
      ncell_pkg::REG_GRID_SIZE_Z: grid_dim[2]  = data;
      ncell_pkg::REG_REACH_X:     reach_dim[0] = data[0];
      ncell_pkg::REG_REACH_Y:     reach_dim[1] = data[0];
      ncell_pkg::REG_REACH_Z:     reach_dim[2] = data[0];
      default: ;
    endcase
  endfunction

  // Clamp [c - r, c + r] to the grid, as a half-open range
  function void clamp_axis(input int unsigned c, input int unsigned r,
                           input int unsigned n,
                           output int unsigned lo, output int unsigned hi);
    lo = (c >= r) ? c - r : 0;
    hi = c + r + 1;
    if (hi > n) hi = n;
  endfunction

  // Expand one center request into its list of cell indexes
  function void note_request(input logic [ncell_pkg::CENTER_W-1:0] cx,
                             input logic [ncell_pkg::CENTER_W-1:0] cy,
                             input logic [ncell_pkg::CENTER_W-1:0] cz);
    int unsigned dim [3];
    int unsigned lo [3];
    int unsigned hi [3];
    int unsigned total;
    int unsigned k;
    int unsigned flat;
    cell_t       entry;
    dim[0] = (grid_dim[0] > GRID_LIMIT) ? GRID_LIMIT : 32'(grid_dim[0]);
    dim[1] = (grid_dim[1] > GRID_LIMIT) ? GRID_LIMIT : 32'(grid_dim[1]);
    dim[2] = (grid_dim[2] > GRID_LIMIT) ? GRID_LIMIT : 32'(grid_dim[2]);
    clamp_axis(32'(cx), 32'(reach_dim[0]), dim[0], lo[0], hi[0]);
    clamp_axis(32'(cy), 32'(reach_dim[1]), dim[1], lo[1], hi[1]);
    clamp_axis(32'(cz), 32'(reach_dim[2]), dim[2], lo[2], hi[2]);
    total = 1;
    for (int a = 0; a < 3; a++) total *= (hi[a] > lo[a]) ? hi[a] - lo[a] : 0;
    requests++;
    if (total == 0) empty_boxes++;
    k = 0;
    // x outermost, z innermost; flag the final cell
    for (int unsigned x = lo[0]; x < hi[0]; x++) begin
      for (int unsigned y = lo[1]; y < hi[1]; y++) begin
        for (int unsigned z = lo[2]; z < hi[2]; z++) begin
          flat        = x + y * dim[0] + z * dim[0] * dim[1];
          entry.index = flat[ncell_pkg::INDEX_W-1:0];
          entry.last  = (k == total - 1);
          pending_cells.insert(pending_cells.size(), entry);
          k++;
        end
      end
    end
  endfunction

  function void check_cell(input logic [ncell_pkg::INDEX_W-1:0] idx, input logic lst);
    cell_t want;
    checked++;
    if (pending_cells.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: nothing pending, actual index %0d last %0b",
               $time, idx, lst);
      return;
    end
    want = pending_cells.pop_front();
    if (want.index !== idx) begin
      errors++;
      $display("%0t: cell_index mismatch: expected %0d, actual %0d",
               $time, want.index, idx);
    end
    if (want.last !== lst) begin
      errors++;
      $display("%0t: last mismatch at index %0d: expected %0b, actual %0b",
               $time, want.index, want.last, lst);
    end
  endfunction

  function int unsigned pending();
    return pending_cells.size();
  endfunction

endclass

module neighbor_cell_enumerator_tb;

  import ncell_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS     = 40;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CENTER_W-1:0]   center_x;
  logic [CENTER_W-1:0]   center_y;
  logic [CENTER_W-1:0]   center_z;
  logic                  out_valid;
  logic                  out_ready;
  logic [INDEX_W-1:0]    cell_index;
  logic                  last;

  bit          quiet;
  bit          hold_off_go;
  int unsigned idle_cycles;
  int unsigned setting_count;

  neighbor_box_scoreboard sb;

  neighbor_cell_enumerator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_index (cell_index),
    .last       (last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Record accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(center_x, center_y, center_z);
      if (out_valid && out_ready) sb.check_cell(cell_index, last);
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no progress for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    int unsigned stretch;
    bit          held;
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (stretch = 0; stretch < HOLD_OFF_CYCLES; stretch++) @(negedge clk);
      end else if (quiet || $urandom_range(0, 99) >= 8) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
      end
    end
  end

  // Offer one center request and hold it until accepted
  task automatic send_center(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                             input logic [CENTER_W-1:0] cz);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending cell, then let dropped boxes clear
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write a spare index and then all six registers; block must be idle
  task automatic load_config(input int unsigned sx, input int unsigned sy,
                             input int unsigned sz, input bit rx, input bit ry,
                             input bit rz);
    logic [CFG_IDX_W-1:0]  idxs [7];
    logic [CFG_DATA_W-1:0] vals [7];
    idxs[0] = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    vals[0] = CFG_DATA_W'($urandom_range(0, 511));
    idxs[1] = REG_GRID_SIZE_X;
    vals[1] = CFG_DATA_W'(sx);
    idxs[2] = REG_GRID_SIZE_Y;
    vals[2] = CFG_DATA_W'(sy);
    idxs[3] = REG_GRID_SIZE_Z;
    vals[3] = CFG_DATA_W'(sz);
    // upper data bits of a reach write carry noise
    idxs[4] = REG_REACH_X;
    vals[4] = {8'($urandom_range(0, 255)), rx};
    idxs[5] = REG_REACH_Y;
    vals[5] = {8'($urandom_range(0, 255)), ry};
    idxs[6] = REG_REACH_Z;
    vals[6] = {8'($urandom_range(0, 255)), rz};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      sb.write_reg(idxs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // Mostly small grids, with the edges and oversize values now and then
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 12) return 1;
    if (r < 50) return $urandom_range(2, 8);
    if (r < 70) return $urandom_range(9, 40);
    if (r < 78) return 256;
    if (r < 90) return $urandom_range(200, 255);
    return $urandom_range(257, 511);
  endfunction

  // Mostly inside the grid or one past its edge, otherwise anywhere
  function automatic logic [CENTER_W-1:0] pick_coord(input int unsigned size);
    int unsigned top;
    top = (size > 255) ? 255 : size;
    if ($urandom_range(0, 99) < 85) return CENTER_W'($urandom_range(0, top));
    return CENTER_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    center_x      = '0;
    center_y      = '0;
    center_z      = '0;
    quiet         = 1'b0;
    hold_off_go   = 1'b0;
    setting_count = 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a one-cell grid, reach one
    send_center(8'd0, 8'd0, 8'd0);
    send_center(8'd1, 8'd1, 8'd1);
    send_center(8'd2, 8'd0, 8'd0);
    send_center(8'd255, 8'd255, 8'd255);
    settle();

    // Full grid: corners, middle, mixed edges
    load_config(256, 256, 256, 1'b1, 1'b1, 1'b1);
    send_center(8'd0, 8'd0, 8'd0);
    send_center(8'd255, 8'd255, 8'd255);
    send_center(8'd128, 8'd64, 8'd200);
    send_center(8'd0, 8'd255, 8'd0);
    send_center(8'd255, 8'd0, 8'd255);
    settle();

    // Small grid with mixed reach, centers on and past the far edge
    load_config(5, 7, 3, 1'b1, 1'b0, 1'b1);
    send_center(8'd5, 8'd6, 8'd3);
    send_center(8'd6, 8'd0, 8'd0);
    send_center(8'd0, 8'd7, 8'd0);
    send_center(8'd2, 8'd3, 8'd1);
    settle();

    // Zero-size axis: every box is empty
    load_config(0, 4, 4, 1'b1, 1'b1, 1'b1);
    send_center(8'd0, 8'd0, 8'd0);
    send_center(8'd1, 8'd1, 8'd1);
    settle();

    // Oversize grid values clamp to the maximum; reach zero
    load_config(511, 300, 257, 1'b0, 1'b0, 1'b0);
    send_center(8'd255, 8'd255, 8'd255);
    send_center(8'd0, 8'd0, 8'd0);
    send_center(8'd17, 8'd200, 8'd99);
    settle();

    // Random phases; first without idling, one with a long output hold-off,
    // one with a sender pause until the block drains
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = (phase == 0);
      if (phase == 3) begin
        sx = $urandom_range(16, 64);
        sy = $urandom_range(16, 64);
        sz = $urandom_range(16, 64);
      end else begin
        sx = pick_size();
        sy = pick_size();
        sz = pick_size();
      end
      load_config(sx, sy, sz, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      if (phase == 3) hold_off_go = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 6 && k == PHASE_ITEMS / 2) settle();
        send_center(pick_coord(sx), pick_coord(sy), pick_coord(sz));
      end
      settle();
    end
    quiet = 1'b0;

    $display("covered %0d center requests over %0d grid settings, %0d with an empty box",
             sb.requests, setting_count, sb.empty_boxes);
    $display("checked %0d cell indexes, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[neighbor_cell_enumerator.f]
rtl/ncell_pkg.sv
rtl/ncell_cfg.sv
rtl/ncell_front.sv
rtl/ncell_queue.sv
rtl/ncell_back.sv
rtl/neighbor_cell_enumerator.sv
test/neighbor_cell_enumerator_tb.sv
